// ----- rtl/core/mm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

  localparam int ELEM_W     = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = ELEM_W / DIGIT_W;
  localparam int KW         = $clog2(NUM_DIGITS);
  localparam int CFG_W      = 5;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

  localparam logic signed [ELEM_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_B_COLS    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_MAC,
    S_RES
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/mm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/matrix_multiply_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | cmd, row_index, col_index, elem_value
// out     | output    | out_valid / out_stall  | row, col, prod_value, saturated, last
// cfg     | input     | cfg_write_en           | cfg_index, cfg_data
//
// a write beat is taken while the core is idle; a compute beat holds the input
// until the sequencer has finished its row, paced by the 16x4 digit multiplier
// (one 4-bit digit of b per step) and the registered read of the element stores
// in_stall is high whenever a compute is in flight; a result waiting on out_stall
// holds the sequencer before the next column. synchronous active-low reset
// clears control and the dimension registers, not the element stores

module matrix_multiply_core #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [mm_pkg::CMD_W-1:0]            in_cmd,
  input  wire logic [mm_pkg::IDX_W-1:0]            in_row_index,
  input  wire logic [mm_pkg::IDX_W-1:0]            in_col_index,
  input  wire logic signed [mm_pkg::ELEM_W-1:0]    in_elem_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [mm_pkg::IDX_W-1:0]                 out_row,
  output logic [mm_pkg::IDX_W-1:0]                 out_col,
  output logic signed [mm_pkg::ELEM_W-1:0]         out_prod_value,
  output logic                                     out_saturated,
  output logic                                     out_last,
  input  wire logic                                cfg_write_en,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mm_pkg::CFG_W-1:0]            cfg_data
);

  import mm_pkg::*;

  localparam int IW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW     = 2 * IW;
  localparam int DEPTH  = 1 << AW;
  localparam int CW     = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (CW > CFG_W) ? CW : CFG_W;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int TERM_W = PROD_W + DIGIT_W + 1;
  localparam int ACC_W  = PROD_W + IW + 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] a_rows_r, inner_dim_r, b_cols_r;
  logic [CW-1:0]    nr_c, nk_c, nc_c;
  logic [CW-1:0]    nk_r, nc_r;

  logic [IW-1:0]    row_r, j_r, n_r, rd_n;
  logic [KW-1:0]    k_r;

  logic signed [PROD_W-1:0] a_sh_r;
  logic [ELEM_W-1:0]        b_sh_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DIGIT_W:0]  digit;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [ACC_W-1:0]  acc_q;
  logic [ACC_W-ELEM_W:0]    acc_hi;
  logic                     sat_pos, sat_neg;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [ELEM_W-1:0] out_value_r;
  logic                     out_sat_r, out_last_r;

  logic in_acc, wr_ok, row_ok, start;
  logic wr_a, wr_b;
  logic k_last, term_last, col_last;
  logic shift_load, res_load;
  cmd_t cmd;

  logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [ELEM_W-1:0] rd_a, rd_b;

  // dimension clamping
  function automatic logic [CW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
      r = CW'(MAX_DIM);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  assign nr_c = clamp_dim(a_rows_r);
  assign nk_c = clamp_dim(inner_dim_r);
  assign nc_c = clamp_dim(b_cols_r);

  assign cmd    = cmd_t'(in_cmd);
  assign in_acc = in_valid && !in_stall;
  assign wr_ok  = (CMP_W'(in_row_index) < CMP_W'(MAX_DIM)) &&
                  (CMP_W'(in_col_index) < CMP_W'(MAX_DIM));
  assign row_ok = CMP_W'(in_row_index) < CMP_W'(nr_c);
  assign start  = in_acc && (cmd == CMD_COMPUTE) && row_ok;
  assign wr_a   = in_acc && (cmd == CMD_WRITE_A) && wr_ok;
  assign wr_b   = in_acc && (cmd == CMD_WRITE_B) && wr_ok;

  assign wr_addr   = {IW'(in_row_index), IW'(in_col_index)};
  assign rd_addr_a = {row_r, rd_n};
  assign rd_addr_b = {rd_n, j_r};

  assign k_last    = (k_r == KW'(NUM_DIGITS - 1));
  assign term_last = ((CW'(n_r) + CW'(1)) == nk_r);
  assign col_last  = ((CW'(j_r) + CW'(1)) == nc_r);

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (in_elem_value),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (in_elem_value),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  // digit-serial multiply: top digit of b is signed
  assign digit    = {k_last & b_sh_r[DIGIT_W-1], b_sh_r[DIGIT_W-1:0]};
  assign term     = a_sh_r * digit;
  assign term_ext = {{(ACC_W-PROD_W-1){term[PROD_W]}}, term[PROD_W:0]};

  assign acc_q   = acc_r >>> FRAC_BITS;
  assign acc_hi  = acc_q[ACC_W-1:ELEM_W-1];
  assign sat_pos = !acc_q[ACC_W-1] && (|acc_hi);
  assign sat_neg = acc_q[ACC_W-1] && !(&acc_hi);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_MAC;
      S_MAC: begin
        if (k_last && term_last) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (res_load) begin
          state_nxt = col_last ? S_IDLE : S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    rd_n       = '0;
    shift_load = 1'b0;
    res_load   = 1'b0;
    acc_nxt    = acc_r;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_FETCH: ;
      S_LOAD: begin
        shift_load = 1'b1;
        acc_nxt    = '0;
      end
      S_MAC: begin
        rd_n       = n_r + IW'(1);
        shift_load = k_last && !term_last;
        acc_nxt    = acc_r + term_ext;
      end
      S_RES: res_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_rows_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      b_cols_r    <= DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_A_ROWS:    a_rows_r    <= cfg_data;
          CFG_INNER_DIM: inner_dim_r <= cfg_data;
          CFG_B_COLS:    b_cols_r    <= cfg_data;
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start) begin
      row_r <= IW'(in_row_index);
      nk_r  <= nk_c;
      nc_r  <= nc_c;
      j_r   <= '0;
    end
    if (state_r == S_LOAD) begin
      n_r <= '0;
      k_r <= '0;
    end else if (state_r == S_MAC) begin
      k_r <= k_r + KW'(1);
      if (k_last) begin
        n_r <= n_r + IW'(1);
      end
    end
    if (shift_load) begin
      a_sh_r <= {{(PROD_W-ELEM_W){rd_a[ELEM_W-1]}}, rd_a};
      b_sh_r <= rd_b;
    end else if (state_r == S_MAC) begin
      a_sh_r <= a_sh_r <<< DIGIT_W;
      b_sh_r <= b_sh_r >> DIGIT_W;
    end
    if (res_load) begin
      out_row_r  <= IDX_W'(row_r);
      out_col_r  <= IDX_W'(j_r);
      out_sat_r  <= sat_pos || sat_neg;
      out_last_r <= col_last;
      if (sat_pos) begin
        out_value_r <= SAT_MAX;
      end else if (sat_neg) begin
        out_value_r <= SAT_MIN;
      end else begin
        out_value_r <= acc_q[ELEM_W-1:0];
      end
      if (!col_last) begin
        j_r <= j_r + IW'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_prod_value = out_value_r;
  assign out_saturated  = out_sat_r;
  assign out_last       = out_last_r;

  a_load_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (state_r == S_MAC) && (k_r == '0) && (n_r == '0))
    else $error("digit sequencer not restarted after load");

  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (CW'(n_r) < nk_r))
    else $error("term index beyond inner dimension");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_prod_value == SAT_MAX) || (out_prod_value == SAT_MIN))
    else $error("saturated beat without clipped value");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && col_last) |=> (state_r == S_IDLE) && out_valid && out_last)
    else $error("row did not end on a last beat");

endmodule

`default_nettype wire

// ----- tb/tb_matrix_multiply_core.sv -----
`timescale 1ns / 1ps

module tb_matrix_multiply_core;
  import mm_pkg::*;

  localparam int MAX_DIM     = 16;
  localparam int FRAC_BITS   = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BEATS = 34;
  localparam int NUM_PHASES  = 6;

  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // rows, inner, cols per phase; zero and out-of-range values clamp in the block
  localparam logic [CFG_W-1:0] PHASE_DIMS [NUM_PHASES][3] = '{
    '{5'd16, 5'd1,  5'd16},
    '{5'd1,  5'd16, 5'd1},
    '{5'd4,  5'd4,  5'd4},
    '{5'd0,  5'd0,  5'd0},
    '{5'd31, 5'd3,  5'd17},
    '{5'd5,  5'd6,  5'd3}
  };

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_RANDOM,
    FLOW_RUNS
  } flow_t;

  typedef struct {
    logic [CMD_W-1:0]         op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] val;
  } mm_beat_t;

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic                     saturated;
    logic                     is_last;
  } mm_prod_t;

  logic                     clk;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic [CMD_W-1:0]         in_cmd         = '0;
  logic [IDX_W-1:0]         in_row_index   = '0;
  logic [IDX_W-1:0]         in_col_index   = '0;
  logic signed [ELEM_W-1:0] in_elem_value  = '0;
  logic                     out_stall      = 1'b0;
  logic                     cfg_write_en   = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index      = '0;
  logic [CFG_W-1:0]         cfg_data       = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [ELEM_W-1:0] out_prod_value;
  logic                     out_saturated;
  logic                     out_last;

  // element stores and dimension registers as the block should hold them
  logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  bit                       a_set [MAX_DIM*MAX_DIM];
  bit                       b_set [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0]         dim_rows  = DIM_RESET;
  logic [CFG_W-1:0]         dim_inner = DIM_RESET;
  logic [CFG_W-1:0]         dim_cols  = DIM_RESET;

  mm_beat_t pending_beats [$];
  mm_prod_t expected_products [$];

  int    beats_queued     = 0;
  int    ignored_queued   = 0;
  int    beats_taken      = 0;
  int    rows_computed    = 0;
  int    products_checked = 0;
  int    saturations      = 0;
  int    mismatches       = 0;
  int    cycle_cnt        = 0;
  logic  in_fire          = 1'b0;
  int    burst_left       = 0;
  int    gap_left         = 0;
  int    seg_left         = 0;
  int    run_left         = 0;
  logic  stall_on         = 1'b0;
  flow_t flow_mode        = FLOW_FREE;
  mm_beat_t nxt;

  matrix_multiply_core #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_elem_value  (in_elem_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_prod_value (out_prod_value),
    .out_saturated  (out_saturated),
    .out_last       (out_last),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int dim_used(input logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    if ($urandom_range(0, 3) == 0) return ELEM_W'($urandom);
    return ELEM_W'($urandom_range(0, 2047) - 1024);
  endfunction

  // store writes, or one row of the product with floor shift and clipping
  function automatic void predict_products(input mm_beat_t bt);
    int       nr;
    int       nk;
    int       nc;
    int       j;
    int       n;
    longint   acc;
    longint   q;
    mm_prod_t p;
    nr = dim_used(dim_rows);
    nk = dim_used(dim_inner);
    nc = dim_used(dim_cols);
    if (bt.op == CMD_WRITE_A) begin
      a_mem[bt.row*MAX_DIM + bt.col] = bt.val;
    end else if (bt.op == CMD_WRITE_B) begin
      b_mem[bt.row*MAX_DIM + bt.col] = bt.val;
    end else if (bt.op == CMD_COMPUTE && bt.row < nr) begin
      rows_computed++;
      for (j = 0; j < nc; j++) begin
        acc = 0;
        for (n = 0; n < nk; n++)
          acc += longint'(a_mem[bt.row*MAX_DIM + n]) * longint'(b_mem[n*MAX_DIM + j]);
        q = acc >>> FRAC_BITS;
        p.row       = bt.row;
        p.col       = IDX_W'(j);
        p.saturated = (q > 32767) || (q < -32768);
        p.value     = (q > 32767) ? SAT_MAX : (q < -32768) ? SAT_MIN : ELEM_W'(q);
        p.is_last   = (j == nc - 1);
        expected_products.push_back(p);
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      CFG_A_ROWS:    dim_rows  = data;
      CFG_INNER_DIM: dim_inner = data;
      CFG_B_COLS:    dim_cols  = data;
      default:       ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic queue_beat(input logic [CMD_W-1:0] op, input int r, input int c,
                            input logic [ELEM_W-1:0] v);
    mm_beat_t bt;
    bt.op  = op;
    bt.row = IDX_W'(r);
    bt.col = IDX_W'(c);
    bt.val = v;
    if (op == CMD_WRITE_A) a_set[r*MAX_DIM + c] = 1'b1;
    if (op == CMD_WRITE_B) b_set[r*MAX_DIM + c] = 1'b1;
    if (op == CMD_UNUSED || (op == CMD_COMPUTE && r >= dim_used(dim_rows)))
      ignored_queued++;
    pending_beats.push_back(bt);
    beats_queued++;
  endtask

  // fill whatever the row still lacks, then ask for it
  task automatic queue_compute(input int r);
    int nk;
    int nc;
    int n;
    int j;
    nk = dim_used(dim_inner);
    nc = dim_used(dim_cols);
    if (r < dim_used(dim_rows)) begin
      for (n = 0; n < nk; n++)
        if (!a_set[r*MAX_DIM + n]) queue_beat(CMD_WRITE_A, r, n, rand_elem());
      for (n = 0; n < nk; n++)
        for (j = 0; j < nc; j++)
          if (!b_set[n*MAX_DIM + j]) queue_beat(CMD_WRITE_B, n, j, rand_elem());
    end
    queue_beat(CMD_COMPUTE, r, $urandom_range(0, 15), ELEM_W'($urandom));
  endtask

  task automatic random_phase(input int target);
    int start;
    int nk;
    start = beats_queued - ignored_queued;
    nk    = dim_used(dim_inner);
    while (beats_queued - ignored_queued - start < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_compute($urandom_range(0, dim_used(dim_rows) - 1));
        6: queue_beat(CMD_WRITE_A, $urandom_range(0, dim_used(dim_rows) - 1),
                      $urandom_range(0, nk - 1), rand_elem());
        7: queue_beat($urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A,
                      $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
        8: queue_compute($urandom_range(0, 15));
        default: queue_beat(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                            ELEM_W'($urandom));
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beats_taken != beats_queued || expected_products.size() != 0);
    repeat (dim_used(dim_cols) * (4 * dim_used(dim_inner) + 3) + 8) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0 || pending_beats.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        nxt = pending_beats.pop_front();
        in_valid      <= 1'b1;
        in_cmd        <= nxt.op;
        in_row_index  <= nxt.row;
        in_col_index  <= nxt.col;
        in_elem_value <= nxt.val;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_left  = $urandom_range(20, 200);
      flow_mode = flow_t'($urandom_range(0, 2));
    end
    seg_left = seg_left - 1;
    case (flow_mode)
      FLOW_FREE:   out_stall <= 1'b0;
      FLOW_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (run_left == 0) begin
          stall_on = !stall_on;
          run_left = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end
        run_left = run_left - 1;
        out_stall <= stall_on;
      end
    endcase
  end

  always @(posedge clk) begin : check_beats
    mm_beat_t taken;
    mm_prod_t want;
    in_fire <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      taken.op  = in_cmd;
      taken.row = in_row_index;
      taken.col = in_col_index;
      taken.val = in_elem_value;
      predict_products(taken);
      beats_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_products.size() == 0) begin
        $error("unexpected product beat: row %0d col %0d value %0d",
               out_row, out_col, out_prod_value);
        mismatches++;
      end else begin
        want = expected_products.pop_front();
        products_checked++;
        if (want.saturated) saturations++;
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, actual %0d", want.row, out_row);
          mismatches++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, actual %0d", want.col, out_col);
          mismatches++;
        end
        if (out_prod_value !== want.value) begin
          $error("prod_value: expected %0d, actual %0d", want.value, out_prod_value);
          mismatches++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %0d, actual %0d", want.saturated, out_saturated);
          mismatches++;
        end
        if (out_last !== want.is_last) begin
          $error("last: expected %0d, actual %0d", want.is_last, out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_A_ROWS, 5'd2);
    write_reg(CFG_INNER_DIM, 5'd2);
    write_reg(CFG_B_COLS, 5'd2);
    write_reg(CFG_UNUSED, 5'd31);

    // clipping both ways, floor just past the negative limit, ignored beats
    queue_beat(CMD_WRITE_A, 0, 0, 16'h7fff);
    queue_beat(CMD_WRITE_A, 0, 1, 16'h7fff);
    queue_beat(CMD_WRITE_B, 0, 0, 16'h7fff);
    queue_beat(CMD_WRITE_B, 1, 0, 16'h7fff);
    queue_beat(CMD_WRITE_B, 0, 1, 16'h8000);
    queue_beat(CMD_WRITE_B, 1, 1, 16'h8000);
    queue_beat(CMD_COMPUTE, 0, 15, 16'hffff);
    queue_beat(CMD_WRITE_A, 1, 0, 16'h0100);
    queue_beat(CMD_WRITE_A, 1, 1, 16'hffff);
    queue_beat(CMD_WRITE_B, 1, 1, 16'h0005);
    queue_beat(CMD_COMPUTE, 1, 0, 16'h0000);
    queue_beat(CMD_COMPUTE, 2, 0, 16'h0000);
    queue_beat(CMD_COMPUTE, 15, 15, 16'h7fff);
    queue_beat(CMD_UNUSED, 15, 15, 16'h8000);
    queue_beat(CMD_WRITE_A, 15, 15, 16'h5a5a);
    queue_beat(CMD_WRITE_B, 15, 15, 16'ha5a5);
    queue_beat(CMD_WRITE_A, 0, 0, 16'h0000);
    queue_beat(CMD_WRITE_A, 0, 1, 16'h0001);
    queue_beat(CMD_COMPUTE, 0, 0, 16'h0000);
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_A_ROWS, PHASE_DIMS[ph][0]);
      write_reg(CFG_INNER_DIM, PHASE_DIMS[ph][1]);
      write_reg(CFG_B_COLS, PHASE_DIMS[ph][2]);
      random_phase(PHASE_BEATS);
      wait_drained();
    end

    $display("%0d input beats over %0d dimension settings, %0d ignored by the block",
             beats_taken, NUM_PHASES + 1, ignored_queued);
    $display("%0d product rows, %0d products checked, %0d of them clipped",
             rows_computed, products_checked, saturations);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
